@@ sv/assert_macros.svh @@
// Concurrent assertion helpers, clocked on clk and quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

@@ sv/btp_pkg.sv @@
package btp_pkg;

    localparam int NOTE_DEPTH_DEF   = 32;
    localparam int BUTTON_COUNT_DEF = 4;
    localparam int TONE_BUTTONS     = 4;
    localparam int RAW_W            = 4;
    localparam int PERIOD_W         = 16;
    localparam int QUARTER_W        = 12;
    localparam int LIMIT_W          = 8;
    localparam int LENGTH_W         = 6;
    localparam int SLOT_W           = 14;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 16;
    localparam int TUNE_NOTES       = 26;

    localparam logic [QUARTER_W-1:0] QUARTER_RST = 12'd1200;
    localparam logic [QUARTER_W-1:0] GAP_RST     = 12'd80;
    localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 8'd10;
    localparam logic [LENGTH_W-1:0]  LENGTH_RST  = 6'd26;
    localparam logic [PERIOD_W-1:0]  TONE0_RST   = 16'd5102;
    localparam logic [PERIOD_W-1:0]  TONE1_RST   = 16'd6065;
    localparam logic [PERIOD_W-1:0]  TONE2_RST   = 16'd7644;
    localparam logic [PERIOD_W-1:0]  TONE3_RST   = 16'd10203;

    localparam logic [PERIOD_W-1:0] TONE_E = 16'd6065;
    localparam logic [PERIOD_W-1:0] TONE_D = 16'd6810;
    localparam logic [PERIOD_W-1:0] TONE_C = 16'd7644;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_QUARTER = 3'd0,
        REG_GAP     = 3'd1,
        REG_LIMIT   = 3'd2,
        REG_LENGTH  = 3'd3,
        REG_TONE0   = 3'd4,
        REG_TONE1   = 3'd5,
        REG_TONE2   = 3'd6,
        REG_TONE3   = 3'd7
    } cfg_reg_t;

    // Note length as a left shift of the quarter: 0, 1 or 2 for 1, 2 or 4 quarters.
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [1:0]          lsh;
    } note_t;

    localparam note_t TUNE [TUNE_NOTES] = '{
        '{TONE_E, 2'd0}, '{TONE_D, 2'd0}, '{TONE_C, 2'd0}, '{TONE_D, 2'd0},
        '{TONE_E, 2'd0}, '{TONE_E, 2'd0}, '{TONE_E, 2'd1},
        '{TONE_D, 2'd0}, '{TONE_D, 2'd0}, '{TONE_D, 2'd1},
        '{TONE_E, 2'd0}, '{TONE_E, 2'd0}, '{TONE_E, 2'd1},
        '{TONE_E, 2'd0}, '{TONE_D, 2'd0}, '{TONE_C, 2'd0}, '{TONE_D, 2'd0},
        '{TONE_E, 2'd0}, '{TONE_E, 2'd0}, '{TONE_E, 2'd0}, '{TONE_C, 2'd0},
        '{TONE_D, 2'd0}, '{TONE_D, 2'd0}, '{TONE_E, 2'd0}, '{TONE_D, 2'd0},
        '{TONE_C, 2'd2}
    };

    // Entries past the fixed tune are one-quarter rests.
    function automatic note_t rom_entry(input logic [7:0] idx);
        note_t n;
        n = '{'0, 2'd0};
        if (idx < 8'(TUNE_NOTES))
        begin
            n = TUNE[idx[4:0]];
        end
        return n;
    endfunction

endpackage

@@ sv/btp_in_if.sv @@
interface btp_in_if;
    logic                           valid;
    logic                           ready;
    logic [btp_pkg::RAW_W-1:0]      raw_buttons;

    modport source (output valid, output raw_buttons, input ready);
    modport sink (input valid, input raw_buttons, output ready);
endinterface

@@ sv/btp_out_if.sv @@
interface btp_out_if;
    logic                           valid;
    logic                           ready;
    logic                           tone_on;
    logic [btp_pkg::PERIOD_W-1:0]   tone_period;
    logic                           button_mode;
    logic [btp_pkg::RAW_W-1:0]      pressed_mask;

    modport source (output valid, output tone_on, output tone_period,
                    output button_mode, output pressed_mask, input ready);
    modport sink (input valid, input tone_on, input tone_period,
                  input button_mode, input pressed_mask, output ready);
endinterface

@@ sv/btp_debounce.sv @@
module btp_debounce #(
    parameter int BUTTON_COUNT = btp_pkg::BUTTON_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic [btp_pkg::RAW_W-1:0]       raw,
    input  logic [btp_pkg::LIMIT_W-1:0]     limit,
    output logic [BUTTON_COUNT-1:0]         pressed
);

    logic [btp_pkg::LIMIT_W-1:0] cnt_reg  [BUTTON_COUNT];
    logic [btp_pkg::LIMIT_W-1:0] cnt_next [BUTTON_COUNT];
    logic [7:0]                  raw_ext;

    assign raw_ext = 8'(raw);

    always_comb
    begin
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            cnt_next[i] = cnt_reg[i];
            if (raw_ext[i])
            begin
                if (cnt_reg[i] < limit)
                begin
                    cnt_next[i] = cnt_reg[i] + 1'b1;
                end
            end
            else if (cnt_reg[i] != '0)
            begin
                cnt_next[i] = cnt_reg[i] - 1'b1;
            end
            pressed[i] = (cnt_next[i] >= limit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

endmodule

@@ sv/buzzer_tune_player_with_debounce.sv @@
// Channel   Role    Payload                                           Transaction
// ticks     sink    raw_buttons[3:0]                                  one timer tick
// results   source  tone_on, tone_period[15:0], button_mode,          one result per tick
//                   pressed_mask[3:0]
// cfg       write   cfg_write, cfg_index[2:0], cfg_data[15:0]         one register write
//
// One tick per cycle unless stalled; its result is valid next cycle, in the result register.
// Debounce, tune step and tone select all settle between the tick input and that register.
// ticks.ready is low only while the result register is full and results.ready is low.
// rst_n clears counters, tune position, mode and the result-valid flag; registers take defaults.
module buzzer_tune_player_with_debounce #(
    parameter int NOTE_DEPTH   = btp_pkg::NOTE_DEPTH_DEF,
    parameter int BUTTON_COUNT = btp_pkg::BUTTON_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    btp_in_if.sink                          ticks,
    btp_out_if.source                       results,
    input  logic                            cfg_write,
    input  logic [btp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [btp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
    localparam int LEN_W = 9;

    logic [btp_pkg::QUARTER_W-1:0] quarter_reg;
    logic [btp_pkg::QUARTER_W-1:0] gap_reg;
    logic [btp_pkg::LIMIT_W-1:0]   limit_reg;
    logic [btp_pkg::LENGTH_W-1:0]  length_reg;
    logic [btp_pkg::PERIOD_W-1:0]  tone_reg [btp_pkg::TONE_BUTTONS];

    logic                          mode_reg, mode_next;
    logic [IDX_W-1:0]              index_reg, index_next;
    logic [btp_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic                          silence_reg, silence_next;

    logic                          res_valid_reg;
    logic                          tone_on_reg, tone_on_next;
    logic [btp_pkg::PERIOD_W-1:0]  period_reg, period_next;
    logic                          bmode_reg;
    logic [btp_pkg::RAW_W-1:0]     mask_reg, mask_next;

    logic                          accept;
    logic [BUTTON_COUNT-1:0]       pressed;
    logic [7:0]                    pressed_ext;
    btp_pkg::note_t                cur_note, out_note;
    logic [btp_pkg::SLOT_W-1:0]    total, sound, tick_inc;
    logic [LEN_W-1:0]              used_len, index_inc;
    logic                          btn_on;
    logic [btp_pkg::PERIOD_W-1:0]  btn_period;

    assign accept        = ticks.valid && ticks.ready;
    assign ticks.ready   = !res_valid_reg || results.ready;

    btp_debounce #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_debounce (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .raw     (ticks.raw_buttons),
        .limit   (limit_reg),
        .pressed (pressed)
    );

    assign pressed_ext = 8'(pressed);
    assign mask_next   = pressed_ext[btp_pkg::RAW_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quarter_reg <= btp_pkg::QUARTER_RST;
            gap_reg     <= btp_pkg::GAP_RST;
            limit_reg   <= btp_pkg::LIMIT_RST;
            length_reg  <= btp_pkg::LENGTH_RST;
            tone_reg[0] <= btp_pkg::TONE0_RST;
            tone_reg[1] <= btp_pkg::TONE1_RST;
            tone_reg[2] <= btp_pkg::TONE2_RST;
            tone_reg[3] <= btp_pkg::TONE3_RST;
        end
        else if (cfg_write)
        begin
            case (btp_pkg::cfg_reg_t'(cfg_index))
                btp_pkg::REG_QUARTER: quarter_reg <= cfg_data[btp_pkg::QUARTER_W-1:0];
                btp_pkg::REG_GAP:     gap_reg     <= cfg_data[btp_pkg::QUARTER_W-1:0];
                btp_pkg::REG_LIMIT:   limit_reg   <= cfg_data[btp_pkg::LIMIT_W-1:0];
                btp_pkg::REG_LENGTH:  length_reg  <= cfg_data[btp_pkg::LENGTH_W-1:0];
                btp_pkg::REG_TONE0:   tone_reg[0] <= cfg_data;
                btp_pkg::REG_TONE1:   tone_reg[1] <= cfg_data;
                btp_pkg::REG_TONE2:   tone_reg[2] <= cfg_data;
                btp_pkg::REG_TONE3:   tone_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Slot timing for the note now playing.
    always_comb
    begin
        cur_note = btp_pkg::rom_entry(8'(index_reg));
        total    = btp_pkg::SLOT_W'(quarter_reg) << cur_note.lsh;
        sound    = (total > btp_pkg::SLOT_W'(gap_reg))
                   ? total - btp_pkg::SLOT_W'(gap_reg) : '0;
        tick_inc = slot_reg + 1'b1;

        if (length_reg == '0)
        begin
            used_len = LEN_W'(1);
        end
        else if (LEN_W'(length_reg) > LEN_W'(NOTE_DEPTH))
        begin
            used_len = LEN_W'(NOTE_DEPTH);
        end
        else
        begin
            used_len = LEN_W'(length_reg);
        end
        index_inc = LEN_W'(index_reg) + 1'b1;
    end

    always_comb
    begin
        mode_next    = mode_reg;
        index_next   = index_reg;
        slot_next    = slot_reg;
        silence_next = silence_reg;
        if (!mode_reg)
        begin
            if (pressed != '0)
            begin
                mode_next = 1'b1;
            end
            else
            begin
                slot_next    = tick_inc;
                silence_next = silence_reg || (tick_inc >= sound);
                if (tick_inc >= total)
                begin
                    index_next   = (index_inc >= used_len) ? '0 : index_inc[IDX_W-1:0];
                    slot_next    = '0;
                    silence_next = 1'b0;
                end
            end
        end
    end

    // Lowest-numbered pressed button wins.
    always_comb
    begin
        btn_on     = 1'b0;
        btn_period = '0;
        for (int i = BUTTON_COUNT - 1; i >= 0; i--)
        begin
            if (pressed[i])
            begin
                btn_on     = 1'b1;
                btn_period = (i < btp_pkg::TONE_BUTTONS) ? tone_reg[2'(i)] : '0;
            end
        end
    end

    always_comb
    begin
        out_note = btp_pkg::rom_entry(8'(index_next));
        if (mode_next)
        begin
            tone_on_next = btn_on;
            period_next  = btn_period;
        end
        else if (!silence_next && out_note.period != '0)
        begin
            tone_on_next = 1'b1;
            period_next  = out_note.period;
        end
        else
        begin
            tone_on_next = 1'b0;
            period_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            index_reg     <= '0;
            slot_reg      <= '0;
            silence_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg    <= mode_next;
                index_reg   <= index_next;
                slot_reg    <= slot_next;
                silence_reg <= silence_next;
            end
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tone_on_reg <= tone_on_next;
            period_reg  <= period_next;
            bmode_reg   <= mode_next;
            mask_reg    <= mask_next;
        end
    end

    assign results.valid        = res_valid_reg;
    assign results.tone_on      = tone_on_reg;
    assign results.tone_period  = period_reg;
    assign results.button_mode  = bmode_reg;
    assign results.pressed_mask = mask_reg;

endmodule

@@ sv/btp_checker.sv @@
`include "assert_macros.svh"

module btp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             res_valid,
    input logic                             res_ready,
    input logic                             tone_on,
    input logic [btp_pkg::PERIOD_W-1:0]     tone_period,
    input logic                             button_mode,
    input logic [btp_pkg::RAW_W-1:0]        pressed_mask
);

    logic seen_button_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_button_reg <= 1'b0;
        end
        else if (res_valid && res_ready && button_mode)
        begin
            seen_button_reg <= 1'b1;
        end
    end

    `ASSERT_SAME(a_mode_sticky, res_valid && seen_button_reg, button_mode)
    `ASSERT_SAME(a_off_zero_period, res_valid && !tone_on, tone_period == '0)
    `ASSERT_SAME(a_tune_no_press, res_valid && !button_mode, pressed_mask == '0)
    `ASSERT_NEXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable(tone_on) && $stable(tone_period) && $stable(button_mode) && $stable(pressed_mask))

endmodule

bind buzzer_tune_player_with_debounce btp_checker u_btp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (results.valid),
    .res_ready    (results.ready),
    .tone_on      (results.tone_on),
    .tone_period  (results.tone_period),
    .button_mode  (results.button_mode),
    .pressed_mask (results.pressed_mask)
);
